FILE: rtl/eant_pkg.sv
package eant_pkg;

  localparam int DEF_ENTRIES = 8;
  localparam logic [7:0] EID_MIN = 8'd8;
  localparam logic [7:0] EID_RESERVED = 8'hff;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_LEARN  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  endpoint_id;
    logic [6:0]  bus_addr;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_addr;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [6:0]  addr;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: rtl/eant_mem.sv
module eant_mem #(
  parameter int ENTRIES = eant_pkg::DEF_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  eant_pkg::entry_t wdata,
  input  logic [IW-1:0]    raddr,
  output eant_pkg::entry_t rdata
);

  eant_pkg::entry_t mem [0:ENTRIES-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/eant_ctrl.sv
module eant_ctrl #(
  parameter int ENTRIES = eant_pkg::DEF_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  eant_pkg::in_item_t  in_item,
  output logic                out_valid,
  output eant_pkg::out_item_t out_item,
  output logic                mem_we,
  output logic [IW-1:0]       mem_waddr,
  output eant_pkg::entry_t    mem_wdata,
  output logic [IW-1:0]       mem_raddr,
  input  eant_pkg::entry_t    mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t              state_r, state_nxt;
  eant_pkg::in_item_t  item_r, item_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [31:0]         min_stamp_r, min_stamp_nxt;
  logic [IW-1:0]       min_idx_r, min_idx_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  eant_pkg::out_item_t out_item_r, out_item_nxt;

  logic in_ok;
  logic vld;
  logic match;
  logic is_last;
  logic new_min;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign mem_raddr = rd_idx_r;

  assign in_ok = (in_item.opcode == eant_pkg::OP_LOOKUP) ||
                 (in_item.opcode == eant_pkg::OP_LEARN) ||
                 ((in_item.opcode == eant_pkg::OP_SET) &&
                  (in_item.endpoint_id >= eant_pkg::EID_MIN) &&
                  (in_item.endpoint_id != eant_pkg::EID_RESERVED));

  assign vld     = valid_r[cmp_idx_r];
  assign match   = vld && (mem_rdata.id == item_r.endpoint_id);
  assign is_last = (cmp_idx_r == LAST);
  assign new_min = (cmp_idx_r == '0) || (mem_rdata.stamp < min_stamp_r);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    rd_idx_nxt     = rd_idx_r;
    issue_done_nxt = issue_done_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    min_stamp_nxt  = min_stamp_r;
    min_idx_nxt    = min_idx_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = cmp_idx_r;
    mem_wdata.id    = item_r.endpoint_id;
    mem_wdata.addr  = item_r.bus_addr;
    mem_wdata.stamp = item_r.time_now;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_ok) begin
            state_nxt      = S_SCAN;
            rd_idx_nxt     = '0;
            issue_done_nxt = 1'b0;
          end else begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = eant_pkg::STATUS_INVALID;
            out_item_nxt.found_addr = '0;
          end
        end
      end
      S_SCAN: begin
        if (!issue_done_r) begin
          cmp_v_nxt      = 1'b1;
          cmp_idx_nxt    = rd_idx_r;
          issue_done_nxt = (rd_idx_r == LAST);
          rd_idx_nxt     = rd_idx_r + 1'b1;
        end
        if (cmp_v_r) begin
          if (new_min) begin
            min_stamp_nxt = mem_rdata.stamp;
            min_idx_nxt   = cmp_idx_r;
          end
          out_item_nxt.found_addr = '0;
          out_item_nxt.status     = eant_pkg::STATUS_OK;
          if (item_r.opcode == eant_pkg::OP_LOOKUP) begin
            if (match) begin
              mem_we                  = 1'b1;
              mem_wdata.addr          = mem_rdata.addr;
              out_item_nxt.found_addr = mem_rdata.addr;
              out_valid_nxt           = 1'b1;
              state_nxt               = S_IDLE;
            end else if (is_last) begin
              out_item_nxt.status = eant_pkg::STATUS_NOT_FOUND;
              out_valid_nxt       = 1'b1;
              state_nxt           = S_IDLE;
            end
          end else begin
            if (!vld || match) begin
              mem_we        = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (is_last) begin
              mem_we        = 1'b1;
              mem_waddr     = new_min ? cmp_idx_r : min_idx_r;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          if (mem_we) begin
            valid_nxt[mem_waddr] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_v_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_v_r     <= cmp_v_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    rd_idx_r     <= rd_idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    min_stamp_r  <= min_stamp_nxt;
    min_idx_r    <= min_idx_nxt;
    out_item_r   <= out_item_nxt;
  end

endmodule

FILE: rtl/endpoint_address_neighbour_table_unit.sv
// Endpoint address table: maps 8-bit endpoint IDs to 7-bit bus addresses.
// An item is taken on a rising edge with start high and busy low. The item
// carries an opcode (lookup, checked set, unchecked learn), the endpoint ID,
// the bus address and the caller's current time.
// Each item gives exactly one result on out_item, shown for a single cycle
// with out_valid high. The receiver cannot stall; it must take the result.
// The table lives in a synchronous memory with one read port and one write
// port. The controller reads one entry per cycle, compares it in the next
// cycle, and writes the chosen entry back in the cycle it decides.
// A rejected item (reserved ID on set, unused opcode) gives its result in
// the cycle after the one in which it was taken. A lookup or insert gives
// its result once the scan reaches a hit, for an insert also a free entry,
// or the last entry. The next item can be taken in the cycle in which the
// previous result is shown, and not while busy is high during a scan.
// Reset clears all valid bits at once, so the table starts empty with no
// clearing pass; busy and out_valid are low after reset.
module endpoint_address_neighbour_table_unit #(
  parameter int ENTRIES = eant_pkg::DEF_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  eant_pkg::in_item_t  in_item,
  output logic                out_valid,
  output eant_pkg::out_item_t out_item
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [IW-1:0]    mem_raddr;
  eant_pkg::entry_t mem_wdata;
  eant_pkg::entry_t mem_rdata;

  eant_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  eant_mem #(
    .ENTRIES(ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: rtl/eant_chk.sv
module eant_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input eant_pkg::in_item_t  in_item,
  input logic                out_valid,
  input eant_pkg::out_item_t out_item
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid set after reset");

  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == eant_pkg::STATUS_OK ||
                   out_item.status == eant_pkg::STATUS_NOT_FOUND ||
                   out_item.status == eant_pkg::STATUS_INVALID))
    else $error("unused status code");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != eant_pkg::STATUS_OK |-> out_item.found_addr == '0)
    else $error("found_addr nonzero on failed item");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == eant_pkg::OP_NONE |=>
      out_valid && out_item.status == eant_pkg::STATUS_INVALID && !busy)
    else $error("unused opcode not rejected at once");

  a_reserved_id: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == eant_pkg::OP_SET &&
      (in_item.endpoint_id < eant_pkg::EID_MIN ||
       in_item.endpoint_id == eant_pkg::EID_RESERVED) |=>
      out_valid && out_item.status == eant_pkg::STATUS_INVALID)
    else $error("reserved endpoint ID accepted on set");

endmodule

bind endpoint_address_neighbour_table_unit eant_chk u_chk (.*);

FILE: tb/endpoint_address_neighbour_table_unit_tb.sv
module endpoint_address_neighbour_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = eant_pkg::DEF_ENTRIES;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 2);
  localparam int REPORT_MAX = 10;

  typedef struct {
    eant_pkg::in_item_t item;
    int                 idle_pct;
  } pending_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  eant_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  eant_pkg::out_item_t out_item;

  pending_item_t       pending_q[$];
  eant_pkg::out_item_t expected_q[$];

  logic        tab_valid [ENTRIES];
  logic [7:0]  tab_id    [ENTRIES];
  logic [6:0]  tab_addr  [ENTRIES];
  logic [31:0] tab_stamp [ENTRIES];

  int items_total = 0;
  int items_taken = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  endpoint_address_neighbour_table_unit #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void table_insert(logic [7:0] id, logic [6:0] addr, logic [31:0] now);
    int  pick;
    logic have;
    pick = 0;
    have = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!have && (!tab_valid[i] || tab_id[i] == id)) begin
        pick = i;
        have = 1'b1;
      end
    end
    if (!have) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (tab_stamp[i] < tab_stamp[pick]) begin
          pick = i;
        end
      end
    end
    tab_valid[pick] = 1'b1;
    tab_id[pick]    = id;
    tab_addr[pick]  = addr;
    tab_stamp[pick] = now;
  endfunction

  function automatic eant_pkg::out_item_t table_access(eant_pkg::in_item_t it);
    eant_pkg::out_item_t res;
    res.status     = eant_pkg::STATUS_INVALID;
    res.found_addr = '0;
    case (it.opcode)
      eant_pkg::OP_LOOKUP: begin
        res.status = eant_pkg::STATUS_NOT_FOUND;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tab_valid[i] && tab_id[i] == it.endpoint_id) begin
            tab_stamp[i]   = it.time_now;
            res.found_addr = tab_addr[i];
            res.status     = eant_pkg::STATUS_OK;
            break;
          end
        end
      end
      eant_pkg::OP_SET: begin
        if (it.endpoint_id >= eant_pkg::EID_MIN &&
            it.endpoint_id != eant_pkg::EID_RESERVED) begin
          table_insert(it.endpoint_id, it.bus_addr, it.time_now);
          res.status = eant_pkg::STATUS_OK;
        end
      end
      eant_pkg::OP_LEARN: begin
        table_insert(it.endpoint_id, it.bus_addr, it.time_now);
        res.status = eant_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void add_item(eant_pkg::opcode_t op, logic [7:0] id, logic [6:0] addr,
                                   logic [31:0] now, int idle_pct);
    pending_item_t p;
    p.item.opcode      = op;
    p.item.endpoint_id = id;
    p.item.bus_addr    = addr;
    p.item.time_now    = now;
    p.idle_pct         = idle_pct;
    pending_q.push_back(p);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tab_valid[i] = 1'b0;
        tab_id[i]    = '0;
        tab_addr[i]  = '0;
        tab_stamp[i] = '0;
      end
    end else begin
      if (start && !busy) begin
        expected_q.push_back(table_access(in_item));
        items_taken++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= pending_q[0].idle_pct) begin
          in_item <= pending_q[0].item;
          start   <= 1'b1;
          pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    eant_pkg::out_item_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected result: status %0d found_addr %0d",
                     out_item.status, out_item.found_addr);
          end
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.status !== want.status) begin
            if (mismatches < REPORT_MAX) begin
              $display("status mismatch: expected %0d, got %0d",
                       want.status, out_item.status);
            end
            mismatches++;
          end
          if (out_item.found_addr !== want.found_addr) begin
            if (mismatches < REPORT_MAX) begin
              $display("found_addr mismatch: expected %0d, got %0d",
                       want.found_addr, out_item.found_addr);
            end
            mismatches++;
          end
        end
      end
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("endpoint_address_neighbour_table_unit_tb failed");
    $finish;
  end

  initial begin
    int                idle_pct [4];
    int                r;
    eant_pkg::opcode_t op;
    logic [7:0]        id;
    logic [31:0]       now;
    logic [31:0]       tick;

    idle_pct = '{0, 65, 0, 15};
    tick = 32'd100;

    // Empty table, rejected sets and the unused opcode.
    add_item(eant_pkg::OP_LOOKUP, 8'd5, 7'h7f, 32'd0, 0);
    add_item(eant_pkg::OP_SET, 8'd7, 7'd10, 32'd1, 0);
    add_item(eant_pkg::OP_SET, 8'hff, 7'd10, 32'd1, 0);
    add_item(eant_pkg::OP_SET, 8'd0, 7'd10, 32'd1, 0);
    add_item(eant_pkg::OP_NONE, 8'd40, 7'd10, 32'd1, 0);
    // Learn accepts reserved IDs; set at the edges of the legal range.
    add_item(eant_pkg::OP_LEARN, 8'd0, 7'h7f, 32'd0, 0);
    add_item(eant_pkg::OP_LEARN, 8'hff, 7'd0, 32'd0, 0);
    add_item(eant_pkg::OP_SET, 8'd8, 7'h7f, 32'hffffffff, 0);
    add_item(eant_pkg::OP_SET, 8'd254, 7'd1, 32'd5, 0);
    add_item(eant_pkg::OP_LEARN, 8'd8, 7'd3, 32'd7, 0);
    add_item(eant_pkg::OP_LEARN, 8'd20, 7'h55, 32'd0, 0);
    add_item(eant_pkg::OP_LEARN, 8'd21, 7'h2a, 32'd0, 0);
    add_item(eant_pkg::OP_LEARN, 8'd22, 7'd9, 32'd0, 0);
    add_item(eant_pkg::OP_LEARN, 8'd23, 7'd11, 32'd0, 0);
    // Full table: eviction of the oldest entry, lowest index on a tie.
    add_item(eant_pkg::OP_LEARN, 8'd30, 7'd12, 32'd2, 0);
    add_item(eant_pkg::OP_LOOKUP, 8'hff, 7'h7f, 32'hffffffff, 0);
    add_item(eant_pkg::OP_LOOKUP, 8'd0, 7'd0, 32'd3, 0);
    add_item(eant_pkg::OP_LEARN, 8'd31, 7'd13, 32'd1, 0);
    add_item(eant_pkg::OP_LOOKUP, 8'd254, 7'd0, 32'd4, 0);
    add_item(eant_pkg::OP_LOOKUP, 8'd8, 7'd0, 32'd6, 0);
    add_item(eant_pkg::OP_SET, 8'd32, 7'd14, 32'd8, 0);
    add_item(eant_pkg::OP_NONE, 8'hff, 7'h7f, 32'hffffffff, 0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) op = eant_pkg::OP_LOOKUP;
        else if (r < 65) op = eant_pkg::OP_LEARN;
        else if (r < 93) op = eant_pkg::OP_SET;
        else op = eant_pkg::OP_NONE;
        r = $urandom_range(0, 99);
        if (r < 70) id = 8'($urandom_range(8, 19));
        else if (r < 80) id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'hff;
        else id = 8'($urandom_range(0, 255));
        tick = tick + 32'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 15) now = $urandom;
        else if (r < 18) now = 32'd0;
        else if (r < 21) now = 32'hffffffff;
        else now = tick;
        add_item(op, id, 7'($urandom_range(0, 127)), now, idle_pct[phase]);
      end
    end
    items_total = pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_total || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("endpoint_address_neighbour_table_unit_tb passed");
    end else begin
      $display("endpoint_address_neighbour_table_unit_tb failed");
    end
    $finish;
  end

endmodule
